/* rtl/tlptw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptw_pkg
// Shared types, codes and entry bit positions for the page table walker.
// ----------------------------------------------------------------------------
package tlptw_pkg;

	// entry bit positions
	localparam int unsigned PresentPos = 0;
	localparam int unsigned LeafPos    = 4;

	// input word kinds
	localparam logic KIND_REQUEST  = 1'b0;
	localparam logic KIND_RESPONSE = 1'b1;

	// output word kinds
	localparam logic OUT_MEM_READ = 1'b0;
	localparam logic OUT_RESULT   = 1'b1;

	typedef enum logic [1:0] {
		FLT_OK        = 2'd0,
		FLT_ABSENT    = 2'd1,
		FLT_BAD_ENTRY = 2'd2,
		FLT_DENIED    = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_WAIT_L2 = 2'd1,
		PH_WAIT_L1 = 2'd2
	} phase_t;

	// walk context carried between words
	typedef struct packed {
		phase_t      phase;
		logic [31:0] saved_address;
		logic [1:0]  saved_access;
		logic [31:0] middle_entry;
	} walk_t;

	// one output word
	typedef struct packed {
		logic        kind;
		logic [31:0] mem_addr;
		logic [31:0] phys_addr;
		fault_t      fault;
	} result_t;

	// permission bit selected by access type
	function automatic logic perm_bit(input logic [31:0] entry, input logic [1:0] sel);
		logic [3:0] low;
		low = entry[3:0];
		return low[sel];
	endfunction

	// address of entry idx in the table based at entry[31:12]
	function automatic logic [31:0] entry_addr(input logic [31:0] entry,
			input logic [9:0] idx);
		return {entry[31:12], idx, 2'b00};
	endfunction

endpackage

/* rtl/tlptw_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptw_step
// Combinational walk step: next walk context and the output word for one
// accepted input word.
// ----------------------------------------------------------------------------
module tlptw_step import tlptw_pkg::*; (
	input  logic        kind,
	input  logic [31:0] linear_addr,
	input  logic [1:0]  access_type,
	input  logic [31:0] read_data,
	input  logic [31:0] root_entry,
	input  walk_t       walk,
	output walk_t       walk_next,
	output logic        res_valid,
	output result_t     res
);

	logic busy;
	logic perm_ok;

	assign busy = (walk.phase == PH_WAIT_L2) || (walk.phase == PH_WAIT_L1);

	// permission bit in all three entries
	assign perm_ok = perm_bit(root_entry, walk.saved_access)
		&& perm_bit(walk.middle_entry, walk.saved_access)
		&& perm_bit(read_data, walk.saved_access);

	// next walk context
	always_comb begin
		walk_next = walk;
		if (kind == KIND_REQUEST) begin
			if (!busy && root_entry[PresentPos] && !root_entry[LeafPos]) begin
				walk_next.phase         = PH_WAIT_L2;
				walk_next.saved_address = linear_addr;
				walk_next.saved_access  = access_type;
			end
		end else begin
			case (walk.phase)
				PH_WAIT_L2: begin
					if (read_data[PresentPos] && !read_data[LeafPos]) begin
						walk_next.phase        = PH_WAIT_L1;
						walk_next.middle_entry = read_data;
					end else begin
						walk_next.phase = PH_IDLE;
					end
				end
				PH_WAIT_L1: begin
					walk_next.phase = PH_IDLE;
				end
				default: begin
					walk_next.phase = walk.phase;
				end
			endcase
		end
	end

	// output word
	always_comb begin
		res_valid     = 1'b0;
		res.kind      = OUT_RESULT;
		res.mem_addr  = '0;
		res.phys_addr = '0;
		res.fault     = FLT_OK;
		if (kind == KIND_REQUEST) begin
			if (!busy) begin
				res_valid = 1'b1;
				if (!root_entry[PresentPos]) begin
					res.fault = FLT_ABSENT;
				end else if (root_entry[LeafPos]) begin
					if (root_entry[31:12] != '0) begin
						res.fault = FLT_BAD_ENTRY;
					end else begin
						res.phys_addr = linear_addr;
					end
				end else begin
					res.kind     = OUT_MEM_READ;
					res.mem_addr = entry_addr(root_entry, linear_addr[31:22]);
				end
			end
		end else begin
			case (walk.phase)
				PH_WAIT_L2: begin
					res_valid = 1'b1;
					if (!read_data[PresentPos]) begin
						res.fault = FLT_ABSENT;
					end else if (read_data[LeafPos]) begin
						if (read_data[21:12] != '0) begin
							res.fault = FLT_BAD_ENTRY;
						end else begin
							res.phys_addr = {read_data[31:22], walk.saved_address[21:0]};
						end
					end else begin
						res.kind     = OUT_MEM_READ;
						res.mem_addr = entry_addr(read_data, walk.saved_address[21:12]);
					end
				end
				PH_WAIT_L1: begin
					res_valid = 1'b1;
					if (!read_data[PresentPos]) begin
						res.fault = FLT_ABSENT;
					end else if (!perm_ok) begin
						res.fault = FLT_DENIED;
					end else begin
						res.phys_addr = {read_data[31:12], walk.saved_address[11:0]};
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

endmodule

/* rtl/tlptw_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptw_out_reg
// Output register: holds one word until the consumer takes it, and frees
// itself in the same cycle it is drained.
// ----------------------------------------------------------------------------
module tlptw_out_reg import tlptw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_word,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t word
);

	logic    valid_q;
	result_t word_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign word      = word_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end
	end

endmodule

/* rtl/three_level_page_table_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_page_table_walker
// Walks a root entry register and two in-memory table levels for 32-bit
// linear addresses; emits memory read requests and translation results.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    kind, linear_addr, access_type,
//                                             read_data
// out       output     out_valid / out_ready  out_kind, mem_addr, phys_addr,
//                                             fault_code
// cfg       input      cfg_we                 cfg_wdata (root_entry)
//
// One input word per cycle while in_ready is high; its output word appears
// in the next cycle, set by the single output register after the walk step.
// Reset clears the walk context, the root entry and the output valid flag.
// in_ready drops only while a held output word is not being taken.
// Words that produce no output are still accepted and consumed.
// ----------------------------------------------------------------------------
module three_level_page_table_walker import tlptw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] linear_addr,
	input  logic [1:0]  access_type,
	input  logic [31:0] read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [31:0] mem_addr,
	output logic [31:0] phys_addr,
	output logic [1:0]  fault_code
);

	logic [31:0] root_entry_q;
	walk_t       walk_q;
	walk_t       walk_next;
	logic        res_valid;
	result_t     res;
	logic        can_load;
	logic        accept;
	result_t     out_word;

	assign in_ready = can_load;
	assign accept   = in_valid && in_ready;

	// root entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_entry_q <= '0;
		end else if (cfg_we) begin
			root_entry_q <= cfg_wdata;
		end
	end

	// walk context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '{phase: PH_IDLE, saved_address: '0, saved_access: '0,
				middle_entry: '0};
		end else if (accept) begin
			walk_q <= walk_next;
		end
	end

	// walk step
	tlptw_step u_step (
		.kind        (kind),
		.linear_addr (linear_addr),
		.access_type (access_type),
		.read_data   (read_data),
		.root_entry  (root_entry_q),
		.walk        (walk_q),
		.walk_next   (walk_next),
		.res_valid   (res_valid),
		.res         (res)
	);

	// output register
	tlptw_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && res_valid),
		.load_word (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word      (out_word)
	);

	assign out_kind   = out_word.kind;
	assign mem_addr   = out_word.mem_addr;
	assign phys_addr  = out_word.phys_addr;
	assign fault_code = out_word.fault;

endmodule
